// File: hw/rtl/rnef_pkg.sv
// shared constants and codes for the raster neighbor edge finder
`default_nettype none
package rnef_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int CELL_BITS   = 24;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int COL_BITS    = 16;
  // target may run past the cell width by a column step either way
  localparam int TGT_BITS    = CELL_BITS + 2;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;
  localparam int DIV_STEPS   = CELL_BITS;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_QUEEN  = 2'd0,
    REG_WRAP   = 2'd1,
    REG_COLS   = 2'd2,
    REG_TOTAL  = 2'd3
  } reg_index_t;

  localparam logic [3:0] DIR_NW = 4'd1;
  localparam logic [3:0] DIR_N  = 4'd2;
  localparam logic [3:0] DIR_NE = 4'd3;
  localparam logic [3:0] DIR_W  = 4'd4;
  localparam logic [3:0] DIR_E  = 4'd5;
  localparam logic [3:0] DIR_SW = 4'd6;
  localparam logic [3:0] DIR_S  = 4'd7;
  localparam logic [3:0] DIR_SE = 4'd8;

endpackage
`default_nettype wire

// File: hw/rtl/raster_neighbor_edge_finder.sv
// raster neighbor edge finder: cell table, neighbor arithmetic and table search
//
// Input channel (in_valid/in_ready) carries one item: opcode, cell_number,
// source_index and direction. Clear and append give no result. A query
// gives exactly one result item on the out_ channel: edge_found,
// from_index (the source index) and to_index (neighbor index, zero when
// there is no edge).
// A query reads its source cell from the table, finds its column with a
// remainder unit that takes one bit per cycle, forms the neighbor cell
// number, then does a lower-bound binary search over the loaded entries,
// each probe a table read and then a compare. A query whose source is out
// of range goes straight to its result; one with a bad direction, a rook
// diagonal or a zero source cell stops after the source read, and one that
// runs off an edge stops before the search.
// One item is worked on at a time; in_ready is high only between items.
// A result sits in an output register until taken; while the receiver
// stalls, clears and appends are still accepted, and a finished query waits.
// Reset empties the table (entry count zero, contents left as they are) and
// sets rook mode, no wrap, one column and one cell. The user writes registers
// through the APB port only while the block is idle; it does not enforce this.
`default_nettype none
module raster_neighbor_edge_finder
  import rnef_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [CELL_BITS-1:0] in_cell_number,
  input  wire logic [IDX_BITS-1:0]  in_source_index,
  input  wire logic [3:0]           in_direction,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_edge_found,
  output logic [IDX_BITS-1:0]       out_from_index,
  output logic [IDX_BITS-1:0]       out_to_index,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0]      prdata,
  output logic                      pready
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SRC_RD = 7'b0000010,
    ST_DIVIDE = 7'b0000100,
    ST_TARGET = 7'b0001000,
    ST_SRCH   = 7'b0010000,
    ST_CMP    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  // configuration
  logic                 queen_r;
  logic                 wrap_r;
  logic [COL_BITS-1:0]  ncol_r;
  logic [CELL_BITS-1:0] total_r;
  logic                 cfg_wr;
  reg_index_t           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queen_r <= 1'b0;
      wrap_r  <= 1'b0;
      ncol_r  <= COL_BITS'(1);
      total_r <= CELL_BITS'(1);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_QUEEN: queen_r <= pwdata[0];
        REG_WRAP:  wrap_r  <= pwdata[0];
        REG_COLS:  ncol_r  <= pwdata[COL_BITS-1:0];
        REG_TOTAL: total_r <= pwdata[CELL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_QUEEN: prdata = {{(DATA_BITS-1){1'b0}}, queen_r};
      REG_WRAP:  prdata = {{(DATA_BITS-1){1'b0}}, wrap_r};
      REG_COLS:  prdata = {{(DATA_BITS-COL_BITS){1'b0}}, ncol_r};
      REG_TOTAL: prdata = {{(DATA_BITS-CELL_BITS){1'b0}}, total_r};
      default:   prdata = '0;
    endcase
  end

  // control and datapath registers
  state_t               state_r, state_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic [IDX_BITS-1:0]  src_r, src_nxt;
  logic [3:0]           dir_r, dir_nxt;
  logic [CELL_BITS-1:0] cval_r, cval_nxt;
  logic [CELL_BITS-1:0] dvd_r, dvd_nxt;
  logic [COL_BITS-1:0]  rem_r, rem_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [TGT_BITS-1:0]  tgt_r, tgt_nxt;
  logic [CNT_BITS-1:0]  lo_r, lo_nxt;
  logic [CNT_BITS-1:0]  hi_r, hi_nxt;
  logic [CNT_BITS-1:0]  mid_r, mid_nxt;
  logic                 eq_r, eq_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_BITS-1:0]  to_r, to_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_edge_r, out_edge_nxt;
  logic [IDX_BITS-1:0]  out_from_r, out_from_nxt;
  logic [IDX_BITS-1:0]  out_to_r, out_to_nxt;

  // table memory
  logic [CELL_BITS-1:0] cell_mem [TABLE_DEPTH];
  logic [CELL_BITS-1:0] rd_data_r;
  logic                 mem_we;
  logic [IDX_BITS-1:0]  mem_waddr;
  logic [IDX_BITS-1:0]  mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= in_cell_number;
    end
    rd_data_r <= cell_mem[mem_raddr];
  end

  // combinational helpers
  logic                 in_acc;
  logic [COL_BITS:0]    div_shift;
  logic                 dir_ok, dir_diag, dir_up, dir_down, dir_left, dir_right;
  logic                 top_row;
  logic [COL_BITS:0]    col_inc;
  logic [TGT_BITS-1:0]  ncol_ext, row_term, col_term, target;
  logic                 miss;
  logic [CNT_BITS:0]    mid_sum;
  logic [CNT_BITS-1:0]  mid_c;
  logic                 below;

  assign in_acc    = in_valid & in_ready;
  assign div_shift = {rem_r, dvd_r[CELL_BITS-1]};
  assign ncol_ext  = TGT_BITS'(ncol_r);
  assign col_inc   = {1'b0, rem_r} + (COL_BITS+1)'(1);
  assign top_row   = cval_r <= CELL_BITS'(ncol_r);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c     = mid_sum[CNT_BITS:1];
  assign below     = {{(TGT_BITS-CELL_BITS){1'b0}}, rd_data_r} < tgt_r;

  always_comb begin
    dir_ok    = dir_r inside {[DIR_NW:DIR_SE]};
    dir_up    = dir_r inside {DIR_NW, DIR_N, DIR_NE};
    dir_down  = dir_r inside {DIR_SW, DIR_S, DIR_SE};
    dir_left  = dir_r inside {DIR_NW, DIR_W, DIR_SW};
    dir_right = dir_r inside {DIR_NE, DIR_E, DIR_SE};
    dir_diag  = (dir_up | dir_down) & (dir_left | dir_right);
  end

  // neighbor cell number as an offset from the source cell
  always_comb begin
    miss     = 1'b0;
    row_term = '0;
    col_term = '0;
    if (dir_up) begin
      if (top_row) miss = 1'b1;
      row_term = -ncol_ext;
    end else if (dir_down) begin
      row_term = ncol_ext;
    end
    if (dir_left) begin
      if (rem_r == '0) begin
        if (!wrap_r) miss = 1'b1;
        col_term = ncol_ext - TGT_BITS'(1);
      end else begin
        col_term = '1;
      end
    end else if (dir_right) begin
      if (col_inc >= {1'b0, ncol_r}) begin
        if (!wrap_r) miss = 1'b1;
        col_term = TGT_BITS'(1) - ncol_ext;
      end else begin
        col_term = TGT_BITS'(1);
      end
    end
    target = TGT_BITS'(cval_r) + row_term + col_term;
    if (dir_down && target > TGT_BITS'(total_r)) miss = 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    src_nxt       = src_r;
    dir_nxt       = dir_r;
    cval_nxt      = cval_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    tgt_nxt       = tgt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    eq_nxt        = eq_r;
    hit_nxt       = hit_r;
    to_nxt        = to_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_edge_nxt  = out_edge_r;
    out_from_nxt  = out_from_r;
    out_to_nxt    = out_to_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[IDX_BITS-1:0];
    mem_raddr     = in_source_index;
    in_ready      = state_r == ST_IDLE;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_t'(in_opcode))
            OP_CLEAR: count_nxt = '0;
            OP_APPEND: begin
              if (count_r < CNT_BITS'(TABLE_DEPTH)) begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_BITS'(1);
              end
            end
            OP_QUERY: begin
              src_nxt = in_source_index;
              dir_nxt = in_direction;
              hit_nxt = 1'b0;
              to_nxt  = '0;
              if ({1'b0, in_source_index} >= count_r) begin
                state_nxt = ST_FINISH;
              end else begin
                state_nxt = ST_SRC_RD;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SRC_RD: begin
        cval_nxt = rd_data_r;
        dvd_nxt  = rd_data_r - CELL_BITS'(1);
        rem_nxt  = '0;
        step_nxt = STEP_BITS'(DIV_STEPS - 1);
        if (!dir_ok || ncol_r == '0 || rd_data_r == '0 || (!queen_r && dir_diag)) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_DIVIDE;
        end
      end

      // restoring remainder, one dividend bit a cycle
      ST_DIVIDE: begin
        dvd_nxt = {dvd_r[CELL_BITS-2:0], 1'b0};
        if (div_shift >= {1'b0, ncol_r}) begin
          rem_nxt = COL_BITS'(div_shift - {1'b0, ncol_r});
        end else begin
          rem_nxt = div_shift[COL_BITS-1:0];
        end
        step_nxt = step_r - STEP_BITS'(1);
        if (step_r == '0) state_nxt = ST_TARGET;
      end

      ST_TARGET: begin
        tgt_nxt = target;
        lo_nxt  = '0;
        hi_nxt  = count_r;
        eq_nxt  = 1'b0;
        if (miss) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SRCH;
        end
      end

      ST_SRCH: begin
        mid_nxt   = mid_c;
        mem_raddr = mid_c[IDX_BITS-1:0];
        state_nxt = ST_CMP;
      end

      // lower bound: eq tracks whether the current upper end holds the target
      ST_CMP: begin
        if (below) begin
          lo_nxt = mid_r + CNT_BITS'(1);
        end else begin
          hi_nxt = mid_r;
          eq_nxt = {{(TGT_BITS-CELL_BITS){1'b0}}, rd_data_r} == tgt_r;
        end
        if (lo_nxt < hi_nxt) begin
          state_nxt = ST_SRCH;
        end else begin
          hit_nxt   = eq_nxt;
          to_nxt    = eq_nxt ? lo_nxt[IDX_BITS-1:0] : '0;
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_edge_nxt  = hit_r;
          out_from_nxt  = src_r;
          out_to_nxt    = to_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    dir_r      <= dir_nxt;
    cval_r     <= cval_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    tgt_r      <= tgt_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    eq_r       <= eq_nxt;
    hit_r      <= hit_nxt;
    to_r       <= to_nxt;
    out_edge_r <= out_edge_nxt;
    out_from_r <= out_from_nxt;
    out_to_r   <= out_to_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_edge_found = out_edge_r;
  assign out_from_index = out_from_r;
  assign out_to_index   = out_to_r;

endmodule
`default_nettype wire

// File: test/rnef_checker.sv
// checker for the raster neighbor edge finder: mirrors table and registers, predicts and checks
`timescale 1ns / 1ps
module rnef_checker
  import rnef_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [CELL_BITS-1:0] in_cell_number,
  input  wire logic [IDX_BITS-1:0]  in_source_index,
  input  wire logic [3:0]           in_direction,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 out_edge_found,
  input  wire logic [IDX_BITS-1:0]  out_from_index,
  input  wire logic [IDX_BITS-1:0]  out_to_index,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic                 pready,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output int                        fail_count,
  output int                        results_owed
);

  typedef struct packed {
    logic                found;
    logic [IDX_BITS-1:0] from_idx;
    logic [IDX_BITS-1:0] to_idx;
  } edge_result_t;

  logic [CELL_BITS-1:0] cell_store [TABLE_DEPTH];
  int unsigned          cells_loaded = 0;
  logic                 queen_q = 1'b0;
  logic                 wrap_q = 1'b0;
  logic [COL_BITS-1:0]  cols_q = 16'd1;
  logic [CELL_BITS-1:0] total_q = 24'd1;
  edge_result_t         owed_q [$];

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // neighbor cell number of c toward dir, 0 when the move leaves the raster or is not allowed
  function automatic longint unsigned neighbor_of(longint unsigned c, logic [3:0] dir);
    longint unsigned ncol, row, col, trow, tcol, tgt;
    int dr, dc;
    ncol = 64'(cols_q);
    dr = 0;
    dc = 0;
    case (dir)
      DIR_NW: begin dr = -1; dc = -1; end
      DIR_N:  dr = -1;
      DIR_NE: begin dr = -1; dc = 1; end
      DIR_W:  dc = -1;
      DIR_E:  dc = 1;
      DIR_SW: begin dr = 1; dc = -1; end
      DIR_S:  dr = 1;
      DIR_SE: begin dr = 1; dc = 1; end
      default: return 0;
    endcase
    if (ncol == 0 || c == 0) return 0;
    if (!queen_q && dr != 0 && dc != 0) return 0;
    row = (c - 1) / ncol;
    col = (c - 1) % ncol;
    trow = row;
    tcol = col;
    if (dr < 0) begin
      if (row == 0) return 0;
      trow = row - 1;
    end else if (dr > 0) begin
      trow = row + 1;
    end
    if (dc < 0) begin
      if (col != 0) tcol = col - 1;
      else if (wrap_q) tcol = ncol - 1;
      else return 0;
    end else if (dc > 0) begin
      if (col + 1 < ncol) tcol = col + 1;
      else if (wrap_q) tcol = 0;
      else return 0;
    end
    tgt = trow * ncol + tcol + 1;
    // only southward moves are bounded by the cell total
    if (dr > 0 && tgt > 64'(total_q)) return 0;
    return tgt;
  endfunction

  function automatic edge_result_t predict_edge(logic [IDX_BITS-1:0] src, logic [3:0] dir);
    edge_result_t    r;
    longint unsigned tgt;
    int unsigned     lo, hi, mid;
    r.found = 1'b0;
    r.from_idx = src;
    r.to_idx = '0;
    if (32'(src) >= cells_loaded) return r;
    tgt = neighbor_of(64'(cell_store[src]), dir);
    if (tgt == 0) return r;
    // lower-bound search, so an unsorted table can miss
    lo = 0;
    hi = cells_loaded;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (64'(cell_store[mid[IDX_BITS-1:0]]) < tgt) lo = mid + 1;
      else hi = mid;
    end
    if (lo < cells_loaded && 64'(cell_store[lo[IDX_BITS-1:0]]) == tgt) begin
      r.found = 1'b1;
      r.to_idx = lo[IDX_BITS-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    edge_result_t want;
    if (!rst_n) begin
      fail_count = 0;
      cells_loaded = 0;
      queen_q = 1'b0;
      wrap_q = 1'b0;
      cols_q = 16'd1;
      total_q = 24'd1;
      owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result with no query owed", 64'(out_from_index), 0);
        end else begin
          want = owed_q.pop_front();
          if (out_edge_found !== want.found)
            report_mismatch("edge_found", 64'(out_edge_found), 64'(want.found));
          if (out_from_index !== want.from_idx)
            report_mismatch("from_index", 64'(out_from_index), 64'(want.from_idx));
          if (out_to_index !== want.to_idx)
            report_mismatch("to_index", 64'(out_to_index), 64'(want.to_idx));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[3:2]))
          REG_QUEEN: queen_q = pwdata[0];
          REG_WRAP:  wrap_q = pwdata[0];
          REG_COLS:  cols_q = pwdata[COL_BITS-1:0];
          REG_TOTAL: total_q = pwdata[CELL_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (opcode_t'(in_opcode))
          OP_CLEAR:  cells_loaded = 0;
          OP_APPEND: begin
            // a full table drops the item
            if (cells_loaded < TABLE_DEPTH) begin
              cell_store[cells_loaded[IDX_BITS-1:0]] = in_cell_number;
              cells_loaded++;
            end
          end
          OP_QUERY:  owed_q = {owed_q, predict_edge(in_source_index, in_direction)};
          default: ;
        endcase
      end
    end
    results_owed <= owed_q.size();
  end

endmodule

// File: test/tb_top.sv
// testbench top for the raster neighbor edge finder: stimulus, register setup and verdict
`timescale 1ns / 1ps
module tb_top;
  import rnef_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 1250;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_opcode = OP_CLEAR;
  logic [CELL_BITS-1:0] in_cell_number = '0;
  logic [IDX_BITS-1:0]  in_source_index = '0;
  logic [3:0]           in_direction = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_edge_found;
  logic [IDX_BITS-1:0]  out_from_index;
  logic [IDX_BITS-1:0]  out_to_index;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  logic        calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned random_sent = 0;
  int unsigned loaded = 0;
  int          fail_count;
  int          results_owed;

  raster_neighbor_edge_finder uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_cell_number(in_cell_number), .in_source_index(in_source_index),
    .in_direction(in_direction),
    .out_valid(out_valid), .out_ready(out_ready), .out_edge_found(out_edge_found),
    .out_from_index(out_from_index), .out_to_index(out_to_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rnef_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_cell_number(in_cell_number), .in_source_index(in_source_index),
    .in_direction(in_direction),
    .out_valid(out_valid), .out_ready(out_ready), .out_edge_found(out_edge_found),
    .out_from_index(out_from_index), .out_to_index(out_to_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  always #2 clk = ~clk;

  always @(posedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 14);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input opcode_t op, input logic [CELL_BITS-1:0] num,
                           input logic [IDX_BITS-1:0] src, input logic [3:0] dir);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_cell_number <= num;
    in_source_index <= src;
    in_direction <= dir;
    do @(posedge clk); while (!in_ready);
    if (op == OP_CLEAR) loaded = 0;
    else if (op == OP_APPEND && loaded < TABLE_DEPTH) loaded++;
  endtask

  task automatic ask(input logic [IDX_BITS-1:0] src, input logic [3:0] dir);
    send_item(OP_QUERY, CELL_BITS'($urandom_range(0, 24'hFFFFFF)), src, dir);
  endtask

  task automatic add_cell(input logic [CELL_BITS-1:0] num);
    send_item(OP_APPEND, num, IDX_BITS'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)));
  endtask

  // hold the sender until every query is answered and the block has gone quiet
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic queen, input logic wrap,
                            input logic [COL_BITS-1:0] cols, input logic [CELL_BITS-1:0] total);
    write_reg(REG_QUEEN, {31'd0, queen});
    write_reg(REG_WRAP, {31'd0, wrap});
    write_reg(REG_COLS, {16'd0, cols});
    write_reg(REG_TOTAL, {8'd0, total});
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, CELL_BITS'($urandom_range(0, 24'hFFFFFF)),
              IDX_BITS'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)));
  endtask

  // one random setting: a small patch of the raster loaded sorted, then mostly queries
  task automatic run_round();
    int unsigned          pick, c_eff, w, h, row0, col0, nq;
    longint unsigned      cols, tot, rowmax, num;
    logic [CELL_BITS-1:0] patch_q [$];
    pick = $urandom_range(0, 99);
    if (pick < 35) cols = $urandom_range(2, 8);
    else if (pick < 45) cols = 1;
    else if (pick < 55) cols = 16'hFFFF;
    else if (pick < 60) cols = 0;
    else cols = $urandom_range(1, 16'hFFFF);
    pick = $urandom_range(0, 99);
    if (pick < 50 && cols != 0) begin
      tot = cols * $urandom_range(1, 12);
      tot = tot - $urandom_range(0, 32'(cols - 1));
      if (tot > 24'hFFFFFF) tot = 24'hFFFFFF;
    end else if (pick < 60) tot = 24'hFFFFFF;
    else if (pick < 65) tot = 1;
    else if (pick < 68) tot = 0;
    else tot = $urandom_range(1, 24'hFFFFFF);
    drain_block();
    set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), COL_BITS'(cols),
               CELL_BITS'(tot));

    c_eff = (cols == 0) ? 7 : 32'(cols);
    w = $urandom_range(1, (c_eff < 6) ? c_eff : 6);
    h = $urandom_range(1, 6);
    rowmax = tot / c_eff;
    pick = $urandom_range(0, 3);
    if (pick == 0) row0 = 0;
    else if (pick == 1) row0 = (rowmax > h) ? 32'(rowmax - h + 1) : 0;
    else row0 = $urandom_range(0, 32'(rowmax));
    // patches often straddle the left-right seam so wrap has something to find
    pick = $urandom_range(0, 2);
    if (pick == 0) col0 = c_eff - 1 - $urandom_range(0, w - 1);
    else if (pick == 1) col0 = 0;
    else col0 = $urandom_range(0, c_eff - 1);
    for (int r = 0; r < h; r++) begin
      for (int k = 0; k < w; k++) begin
        num = (longint'(row0) + r) * c_eff + ((col0 + k) % c_eff) + 1;
        if ($urandom_range(0, 99) < 80) patch_q = {patch_q, num[CELL_BITS-1:0]};
      end
    end
    if (patch_q.size() == 0) patch_q = {patch_q, num[CELL_BITS-1:0]};
    patch_q.sort();

    send_clear();
    random_sent++;
    foreach (patch_q[i]) begin
      add_cell(patch_q[i]);
      random_sent++;
    end

    nq = $urandom_range(15, 45);
    for (int q = 0; q < nq; q++) begin
      pick = $urandom_range(0, 99);
      if (pick < 84 && loaded != 0) begin
        if (pick < 78)
          ask(IDX_BITS'($urandom_range(0, loaded - 1)),
              4'($urandom_range(DIR_NW, DIR_SE)));
        else
          ask(IDX_BITS'($urandom_range(0, loaded - 1)), 4'($urandom_range(0, 15)));
        random_sent++;
      end else if (pick < 89) begin
        ask(IDX_BITS'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)));
        random_sent++;
      end else if (pick < 93) begin
        send_item(OP_NONE, CELL_BITS'($urandom_range(0, 24'hFFFFFF)),
                  IDX_BITS'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)));
      end else if (pick < 97) begin
        // out-of-order append breaks the sort
        add_cell(CELL_BITS'($urandom_range(0, 24'hFFFFFF)));
        random_sent++;
      end else if (pick < 99) begin
        add_cell(patch_q[$urandom_range(0, patch_q.size() - 1)]);
        random_sent++;
      end else begin
        send_clear();
        random_sent++;
        foreach (patch_q[i]) begin
          add_cell(patch_q[i]);
          random_sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, empty table
    ask(12'd0, DIR_N);
    send_item(OP_NONE, 24'hFFFFFF, 12'hFFF, 4'hF);

    // queen, 3 columns, 8 cells; cell 5 sits at index 2
    drain_block();
    set_config(1'b1, 1'b0, 16'd3, 24'd8);
    send_item(OP_CLEAR, '0, '0, '0);
    add_cell(24'd2);
    add_cell(24'd4);
    add_cell(24'd5);
    add_cell(24'd6);
    add_cell(24'd8);
    add_cell(24'hFFFFFF);
    ask(12'd2, DIR_N);
    ask(12'd2, DIR_W);
    ask(12'd2, DIR_E);
    ask(12'd2, DIR_S);
    ask(12'd2, DIR_NE);
    ask(12'd2, DIR_SE);
    ask(12'd2, 4'd0);
    ask(12'd2, 4'hF);
    ask(12'hFFF, DIR_N);

    // rook with one wrapped column: sideways moves land on the source itself
    drain_block();
    set_config(1'b0, 1'b1, 16'd1, 24'd8);
    ask(12'd2, DIR_W);
    ask(12'd2, DIR_SE);
    send_item(OP_CLEAR, '0, '0, '0);
    add_cell(24'd0);
    ask(12'd0, DIR_E);

    // no columns at all
    drain_block();
    write_reg(REG_COLS, 32'd0);
    add_cell(24'd7);
    ask(12'd1, DIR_N);

    // long run with no idling: cells 1..150 on a 64-column raster
    drain_block();
    calm = 1'b1;
    set_config(1'b1, 1'b0, 16'd64, 24'd4096);
    send_item(OP_CLEAR, '0, '0, '0);
    for (int i = 1; i <= 150; i++) add_cell(CELL_BITS'(i));
    ask(12'd149, DIR_N);
    ask(12'd149, DIR_E);
    ask(12'd148, DIR_E);
    ask(12'd149, DIR_W);
    ask(12'd0, DIR_SE);
    ask(12'd0, DIR_NW);
    ask(12'd63, DIR_E);
    ask(12'd149, DIR_S);
    for (int i = 0; i < 12; i++)
      ask(IDX_BITS'($urandom_range(0, 149)), 4'($urandom_range(DIR_NW, DIR_SE)));
    drain_block();
    calm = 1'b0;

    while (random_sent < RANDOM_ITEMS) run_round();

    drain_block();
    if (fail_count == 0 && results_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rnef_pkg.sv
hw/rtl/raster_neighbor_edge_finder.sv
test/rnef_checker.sv
test/tb_top.sv
